FILE: design/ftsw_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and helpers for the flat triangle span walker
// no dependencies; every other file refers to it by scoped names
package ftsw_pkg;

  localparam int COORD_BITS = 13;
  localparam int FRAC_BITS  = 16;
  localparam int FIX_W      = COORD_BITS + FRAC_BITS + 5;   // edge and slope fixed point
  localparam int INT_W      = FIX_W - FRAC_BITS;            // integer part of an edge
  localparam int DX_W       = COORD_BITS + 1;               // vertex difference
  localparam int DIVD_W     = COORD_BITS + FRAC_BITS;       // dividend magnitude
  localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);

  localparam int CFG_W      = 12;
  localparam int SCREEN_MAX = 2048;
  localparam int SPAN_X_W   = 11;
  localparam int COLOUR_W   = 32;
  localparam int COUNT_W    = 23;

  localparam int IN_FIELDS_W  = 6 * COORD_BITS + COLOUR_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = COORD_BITS + 2 * SPAN_X_W + COLOUR_W + COUNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // command codes carried on the input tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    SEL_LONG,
    SEL_UPPER,
    SEL_LOWER
  } slope_sel_t;

  typedef struct packed {
    logic       capture;
    logic       sort_load;
    logic       div_start;
    slope_sel_t div_sel;
    logic       slope_wr;
    logic       step_a;
    logic       step_b;
  } cmd_t;

  typedef struct packed {
    logic walking;
    logic div_done;
  } status_t;

  function automatic logic signed [FIX_W-1:0] to_fix(input logic signed [COORD_BITS-1:0] v);
    logic signed [FIX_W-1:0] ext;
    ext    = FIX_W'(v);
    to_fix = ext <<< FRAC_BITS;
  endfunction

endpackage

FILE: design/flat_triangle_span_walker.sv
`timescale 1ns / 1ps
// top level of the flat triangle span walker: stream ports, config port,
// controller and datapath; depends on ftsw_pkg, ftsw_ctrl, ftsw_datapath
//
//   channel   signals                             moves
//   s         s_tvalid s_tready s_tdata s_tuser   load or step items
//   m         m_tvalid m_tready m_tdata m_tuser   span items, m_tlast ends a triangle
//             m_tlast
//   cfg       cfg_we cfg_index cfg_data           screen width / height writes
//
// a step item goes through accept, edge select and advance, then clip and count
// a load item sorts the vertices and then sets up its slopes:
//   the three slopes go one after another through a single bit-serial divider
// a step while no triangle is active and a load give no span item
// the span item sits in an output register; the next item is taken while it waits,
//   and a later step only stalls in its clip phase until that register empties
// rst is synchronous: no triangle active, width 320, height 200
module flat_triangle_span_walker (
  input  logic                                clk,
  input  logic                                rst,
  // a_x, a_y, b_x, b_y, c_x, c_y (13 bits each), fill_colour (32), zero pad
  input  logic [ftsw_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                                s_tuser,   // command
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // span_row (13), span_left (11), span_right (11), span_colour (32),
  // pixel_total (23), zero pad
  output logic [ftsw_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tuser,   // span_valid
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [ftsw_pkg::CFG_W-1:0]          cfg_data
);

  localparam int CB = ftsw_pkg::COORD_BITS;

  ftsw_pkg::cmd_t    cmd;
  ftsw_pkg::status_t status;

  logic signed [CB-1:0]              span_row;
  logic [ftsw_pkg::SPAN_X_W-1:0]     span_left, span_right;
  logic [ftsw_pkg::COLOUR_W-1:0]     span_colour;
  logic [ftsw_pkg::COUNT_W-1:0]      pixel_total;
  logic                              span_valid;

  ftsw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // input fields sit back to back from bit 0
  ftsw_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .vert_a_x    ($signed(s_tdata[0*CB +: CB])),
    .vert_a_y    ($signed(s_tdata[1*CB +: CB])),
    .vert_b_x    ($signed(s_tdata[2*CB +: CB])),
    .vert_b_y    ($signed(s_tdata[3*CB +: CB])),
    .vert_c_x    ($signed(s_tdata[4*CB +: CB])),
    .vert_c_y    ($signed(s_tdata[5*CB +: CB])),
    .fill_colour (s_tdata[6*CB +: ftsw_pkg::COLOUR_W]),
    .span_row    (span_row),
    .span_left   (span_left),
    .span_right  (span_right),
    .span_colour (span_colour),
    .span_valid  (span_valid),
    .last        (m_tlast),
    .pixel_total (pixel_total)
  );

  assign m_tdata = ftsw_pkg::OUT_DATA_W'({pixel_total, span_colour, span_right,
                                          span_left, span_row});
  assign m_tuser = span_valid;

  // a load never produces a span item
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ftsw_pkg::CMD_LOAD) |=> !$rose(m_tvalid))
    else $error("span item raised right after a load");

  // slope setup keeps the input closed
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ftsw_pkg::CMD_LOAD) |=> !s_tready)
    else $error("input ready during triangle setup");

  // an invalid span reports zero columns
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !span_valid |-> (span_left == '0) && (span_right == '0))
    else $error("invalid span with nonzero columns");

  // a valid span is ordered after clipping
  a_valid_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && span_valid |-> span_left <= span_right)
    else $error("valid span with left past right");

endmodule

FILE: design/ftsw_div.sv
`timescale 1ns / 1ps
// iterative signed divider for the edge slopes, one quotient bit per cycle
// depends on ftsw_pkg
module ftsw_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [ftsw_pkg::DIVD_W-1:0]           dividend,
  input  logic [ftsw_pkg::COORD_BITS-1:0]       divisor,
  input  logic                                  negate,
  output logic                                  done,
  output logic signed [ftsw_pkg::FIX_W-1:0]     quotient
);

  logic                                 busy;
  logic [ftsw_pkg::DIV_CNT_W-1:0]       cnt;
  logic [ftsw_pkg::COORD_BITS-1:0]      rem;
  logic [ftsw_pkg::DIVD_W-1:0]          quo;
  logic                                 neg;
  logic                                 zero;
  logic [ftsw_pkg::COORD_BITS:0]        rem_sh;
  logic [ftsw_pkg::COORD_BITS:0]        diff;
  logic                                 fits;
  logic signed [ftsw_pkg::FIX_W-1:0]    mag_ext;

  assign rem_sh = {rem, quo[ftsw_pkg::DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ftsw_pkg::DIV_CNT_W'(ftsw_pkg::DIVD_W);
      end else if (busy) begin
        cnt <= cnt - ftsw_pkg::DIV_CNT_W'(1);
        if (cnt == ftsw_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring step: shift in the next dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      neg  <= negate;
      zero <= (divisor == '0);
    end else if (busy) begin
      rem <= fits ? diff[ftsw_pkg::COORD_BITS-1:0] : rem_sh[ftsw_pkg::COORD_BITS-1:0];
      quo <= {quo[ftsw_pkg::DIVD_W-2:0], fits};
    end
  end

  assign mag_ext  = $signed({{(ftsw_pkg::FIX_W - ftsw_pkg::DIVD_W){1'b0}}, quo});
  // zero height half gives a zero slope; otherwise truncate toward zero
  assign quotient = zero ? '0 : (neg ? -mag_ext : mag_ext);

endmodule

FILE: design/ftsw_datapath.sv
`timescale 1ns / 1ps
// datapath: vertex sort, slope setup through the divider, edge walk and clip
// depends on ftsw_pkg and ftsw_div
module ftsw_datapath (
  input  logic                                      clk,
  input  logic                                      rst,
  input  ftsw_pkg::cmd_t                            cmd,
  output ftsw_pkg::status_t                         status,
  input  logic                                      cfg_we,
  input  logic                                      cfg_index,
  input  logic [ftsw_pkg::CFG_W-1:0]                cfg_data,
  input  logic signed [ftsw_pkg::COORD_BITS-1:0]    vert_a_x,
  input  logic signed [ftsw_pkg::COORD_BITS-1:0]    vert_a_y,
  input  logic signed [ftsw_pkg::COORD_BITS-1:0]    vert_b_x,
  input  logic signed [ftsw_pkg::COORD_BITS-1:0]    vert_b_y,
  input  logic signed [ftsw_pkg::COORD_BITS-1:0]    vert_c_x,
  input  logic signed [ftsw_pkg::COORD_BITS-1:0]    vert_c_y,
  input  logic [ftsw_pkg::COLOUR_W-1:0]             fill_colour,
  output logic signed [ftsw_pkg::COORD_BITS-1:0]    span_row,
  output logic [ftsw_pkg::SPAN_X_W-1:0]             span_left,
  output logic [ftsw_pkg::SPAN_X_W-1:0]             span_right,
  output logic [ftsw_pkg::COLOUR_W-1:0]             span_colour,
  output logic                                      span_valid,
  output logic                                      last,
  output logic [ftsw_pkg::COUNT_W-1:0]              pixel_total
);

  localparam int CB = ftsw_pkg::COORD_BITS;
  localparam int FW = ftsw_pkg::FIX_W;
  localparam int IW = ftsw_pkg::INT_W;
  localparam int DW = ftsw_pkg::DX_W;

  // configuration
  logic [ftsw_pkg::CFG_W-1:0] scr_w, scr_h, w_eff, h_eff;

  // captured item
  logic signed [CB-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
  logic [ftsw_pkg::COLOUR_W-1:0] r_colour;

  // sorted vertices and walk state
  logic signed [CB-1:0] s_x0, s_y0, s_x1, s_y1, s_x2, s_y2, tmp_x, tmp_y;
  logic signed [CB-1:0] top_x, top_y, bot_x, middle_x, middle_row, end_row, cur_row;
  logic signed [FW-1:0] edge_long, edge_short, slope_long, slope_upper, slope_lower;
  logic [ftsw_pkg::COLOUR_W-1:0] held_colour;
  logic [ftsw_pkg::COUNT_W-1:0]  pixel_count, count_next;
  logic walking;

  // divider operands
  logic signed [DW-1:0] dx, dy, dx_abs;
  logic [ftsw_pkg::DIVD_W-1:0] dividend;
  logic div_done;
  logic signed [FW-1:0] quotient;

  // step stage registers
  logic signed [FW-1:0] short_eff, lft, rgt;
  logic signed [IW-1:0] xl_q, xr_q, xlc, xrc, w_s, h_s, len;
  logic signed [DW-1:0] row_inc;
  logic signed [CB-1:0] row_q;
  logic row_on_q, done_q, valid;

  // configuration writes, clamped on use
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= ftsw_pkg::CFG_W'(320);
      scr_h <= ftsw_pkg::CFG_W'(200);
    end else if (cfg_we) begin
      case (cfg_index)
        ftsw_pkg::REG_WIDTH:  scr_w <= cfg_data;
        ftsw_pkg::REG_HEIGHT: scr_h <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (scr_w > ftsw_pkg::CFG_W'(ftsw_pkg::SCREEN_MAX)) ?
                 ftsw_pkg::CFG_W'(ftsw_pkg::SCREEN_MAX) : scr_w;
  assign h_eff = (scr_h > ftsw_pkg::CFG_W'(ftsw_pkg::SCREEN_MAX)) ?
                 ftsw_pkg::CFG_W'(ftsw_pkg::SCREEN_MAX) : scr_h;
  assign w_s   = $signed(IW'({1'b0, w_eff}));
  assign h_s   = $signed(IW'({1'b0, h_eff}));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_ax     <= vert_a_x;
      r_ay     <= vert_a_y;
      r_bx     <= vert_b_x;
      r_by     <= vert_b_y;
      r_cx     <= vert_c_x;
      r_cy     <= vert_c_y;
      r_colour <= fill_colour;
    end
  end

  // three compare-and-swap stages, swap only on strictly greater y
  always_comb begin
    s_x0 = r_ax; s_y0 = r_ay;
    s_x1 = r_bx; s_y1 = r_by;
    s_x2 = r_cx; s_y2 = r_cy;
    tmp_x = '0;  tmp_y = '0;
    if (s_y0 > s_y1) begin
      tmp_x = s_x0; tmp_y = s_y0;
      s_x0 = s_x1;  s_y0 = s_y1;
      s_x1 = tmp_x; s_y1 = tmp_y;
    end
    if (s_y0 > s_y2) begin
      tmp_x = s_x0; tmp_y = s_y0;
      s_x0 = s_x2;  s_y0 = s_y2;
      s_x2 = tmp_x; s_y2 = tmp_y;
    end
    if (s_y1 > s_y2) begin
      tmp_x = s_x1; tmp_y = s_y1;
      s_x1 = s_x2;  s_y1 = s_y2;
      s_x2 = tmp_x; s_y2 = tmp_y;
    end
  end

  // slope operands for the edge being set up
  always_comb begin
    case (cmd.div_sel)
      ftsw_pkg::SEL_LONG: begin
        dx = DW'(bot_x) - DW'(top_x);
        dy = DW'(end_row) - DW'(top_y);
      end
      ftsw_pkg::SEL_UPPER: begin
        dx = DW'(middle_x) - DW'(top_x);
        dy = DW'(middle_row) - DW'(top_y);
      end
      ftsw_pkg::SEL_LOWER: begin
        dx = DW'(bot_x) - DW'(middle_x);
        dy = DW'(end_row) - DW'(middle_row);
      end
      default: begin
        dx = '0;
        dy = '0;
      end
    endcase
  end

  assign dx_abs   = dx[DW-1] ? -dx : dx;
  assign dividend = {dx_abs[CB-1:0], {ftsw_pkg::FRAC_BITS{1'b0}}};

  ftsw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (dy[CB-1:0]),
    .negate   (dx[DW-1]),
    .done     (div_done),
    .quotient (quotient)
  );

  // step, first half: pick edges, advance accumulators
  assign short_eff = (cur_row == middle_row) ? ftsw_pkg::to_fix(middle_x) : edge_short;
  assign lft       = (edge_long < short_eff) ? edge_long : short_eff;
  assign rgt       = (edge_long < short_eff) ? short_eff : edge_long;
  assign row_inc   = DW'(cur_row) + DW'(1);

  // step, second half: clip and count
  assign xlc        = xl_q[IW-1] ? '0 : xl_q;
  assign xrc        = (xr_q >= w_s) ? (w_s - IW'(1)) : xr_q;
  assign valid      = row_on_q && (xrc >= xlc);
  assign len        = xrc - xlc + IW'(1);
  assign count_next = pixel_count + ftsw_pkg::COUNT_W'($unsigned(len));

  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
    end else if (cmd.sort_load) begin
      walking <= (s_y2 != s_y0);
    end else if (cmd.step_a && row_inc >= DW'(end_row)) begin
      walking <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_load) begin
      top_x       <= s_x0;
      top_y       <= s_y0;
      middle_x    <= s_x1;
      middle_row  <= s_y1;
      bot_x       <= s_x2;
      end_row     <= s_y2;
      cur_row     <= s_y0;
      edge_long   <= ftsw_pkg::to_fix(s_x0);
      edge_short  <= ftsw_pkg::to_fix(s_x0);
      held_colour <= r_colour;
      pixel_count <= '0;
    end
    if (cmd.slope_wr) begin
      case (cmd.div_sel)
        ftsw_pkg::SEL_LONG:  slope_long  <= quotient;
        ftsw_pkg::SEL_UPPER: slope_upper <= quotient;
        ftsw_pkg::SEL_LOWER: slope_lower <= quotient;
        default: ;
      endcase
    end
    if (cmd.step_a) begin
      xl_q       <= lft[FW-1:ftsw_pkg::FRAC_BITS];
      xr_q       <= rgt[FW-1:ftsw_pkg::FRAC_BITS];
      row_q      <= cur_row;
      row_on_q   <= (cur_row >= 0) && (IW'(cur_row) < h_s);
      done_q     <= row_inc >= DW'(end_row);
      edge_long  <= edge_long + slope_long;
      edge_short <= short_eff + ((cur_row < middle_row) ? slope_upper : slope_lower);
      cur_row    <= row_inc[CB-1:0];
    end
    if (cmd.step_b) begin
      span_row    <= row_q;
      span_left   <= valid ? xlc[ftsw_pkg::SPAN_X_W-1:0] : '0;
      span_right  <= valid ? xrc[ftsw_pkg::SPAN_X_W-1:0] : '0;
      span_colour <= held_colour;
      span_valid  <= valid;
      last        <= done_q;
      pixel_total <= valid ? count_next : pixel_count;
      if (valid) begin
        pixel_count <= count_next;
      end
    end
  end

  assign status.walking  = walking;
  assign status.div_done = div_done;

endmodule

FILE: design/ftsw_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences load, slope setup and the two step phases
// depends on ftsw_pkg
module ftsw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               command,
  output logic               m_tvalid,
  input  logic               m_tready,
  output ftsw_pkg::cmd_t     cmd,
  input  ftsw_pkg::status_t  status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_STEP_A,
    ST_STEP_B
  } state_t;

  state_t               state;
  ftsw_pkg::slope_sel_t div_sel;
  logic                 accept;
  logic                 out_free;
  logic                 m_tvalid_next;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = div_sel;
    cmd.capture   = accept;
    cmd.sort_load = (state == ST_SORT);
    cmd.div_start = (state == ST_DIV_GO);
    cmd.slope_wr  = (state == ST_DIV_WAIT) && status.div_done;
    cmd.step_a    = (state == ST_STEP_A);
    cmd.step_b    = (state == ST_STEP_B) && out_free;
  end

  // output valid: raised by the clip phase, dropped once the item is taken
  assign m_tvalid_next = cmd.step_b ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      div_sel  <= ftsw_pkg::SEL_LONG;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (command == ftsw_pkg::CMD_LOAD) begin
              state <= ST_SORT;
            end else if (status.walking) begin
              state <= ST_STEP_A;
            end
          end
        end
        ST_SORT: begin
          div_sel <= ftsw_pkg::SEL_LONG;
          state   <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (status.div_done) begin
            case (div_sel)
              ftsw_pkg::SEL_LONG: begin
                div_sel <= ftsw_pkg::SEL_UPPER;
                state   <= ST_DIV_GO;
              end
              ftsw_pkg::SEL_UPPER: begin
                div_sel <= ftsw_pkg::SEL_LOWER;
                state   <= ST_DIV_GO;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_STEP_A: begin
          state <= ST_STEP_B;
        end
        ST_STEP_B: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
